/* rtl/spimf_pkg.sv */
`default_nettype none

package spimf_pkg;

  // command codes of an input item
  localparam logic [1:0] CMD_TICK  = 2'd0;
  localparam logic [1:0] CMD_WRITE = 2'd1;
  localparam logic [1:0] CMD_READ  = 2'd2;

  // register select
  localparam logic REG_CTRL = 1'b0;
  localparam logic REG_DATA = 1'b1;

  // control word bits
  localparam int CTRL_TA_BIT     = 7;
  localparam int CTRL_CLR_TX_BIT = 4;
  localparam int CTRL_CLR_RX_BIT = 5;

  // status word bits
  localparam int STAT_TXD_BIT  = 18;
  localparam int STAT_RXD_BIT  = 17;
  localparam int STAT_DONE_BIT = 16;
  localparam int STAT_TA_BIT   = 7;

  // divider handling
  localparam logic [15:0] DIV_MASK    = 16'hfffe;
  localparam logic [15:0] HALF_PER_MAX = 16'd32768;

  typedef struct packed {
    logic [1:0]  cmd;
    logic        reg_index;
    logic [31:0] write_data;
    logic        miso;
  } in_item_t;

  typedef struct packed {
    logic [31:0] read_data;
    logic        sclk;
    logic        mosi;
    logic        select_n;
  } out_item_t;

endpackage

`default_nettype wire

/* rtl/spi_master_with_fifos_top.sv */
`default_nettype none

// channel | ports                          | moves
// --------+--------------------------------+-------------------------------------
// in      | in_valid, in_stall, in_data    | one tick, register write or read item
// out     | out_valid, out_stall, out_data | one result item per input item
// cfg     | cfg_we, cfg_wdata              | clock divider write, no wait
//
// an item's result is offered from the result register: the item is taken into the input
// register, then one pass of shifter/fifo logic leads into the result register;
// one item per cycle sustained while out_stall is low, set by that single pass and
// the prefetched fifo read registers.
// synchronous active-low reset clears control state; fifo contents undefined.
// out_stall holds the result register and, once the input register is also
// full, raises in_stall in the same cycle.

module spi_master_with_fifos_top #(
  parameter int FIFO_DEPTH = 16
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire spimf_pkg::in_item_t  in_data,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output spimf_pkg::out_item_t      out_data,
  input  wire logic                 cfg_we,
  input  wire logic [15:0]          cfg_wdata
);
  import spimf_pkg::*;

  localparam int AW = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int CW = $clog2(FIFO_DEPTH + 1);
  localparam logic [AW-1:0] HEAD_LAST = AW'(FIFO_DEPTH - 1);
  localparam logic [CW-1:0] CNT_FULL  = CW'(FIFO_DEPTH);
  localparam logic [AW:0]   DEPTH_EXT = (AW+1)'(FIFO_DEPTH);

  // input register stage
  logic     s1_valid_r;
  in_item_t s1_item_r;
  logic     advance;

  // result register
  logic      out_valid_r;
  out_item_t out_item_r;

  // configuration
  logic [15:0] div_r;

  // fifo bookkeeping
  logic [AW-1:0] tx_head_r, tx_head_nxt;
  logic [CW-1:0] tx_count_r, tx_count_nxt;
  logic [AW-1:0] rx_head_r, rx_head_nxt;
  logic [CW-1:0] rx_count_r, rx_count_nxt;

  // shifter
  logic        active_r, active_nxt;
  logic [7:0]  shift_r, shift_nxt;
  logic [3:0]  bits_r, bits_nxt;
  logic [15:0] ticks_r, ticks_nxt;
  logic        lvl_r, lvl_nxt;
  logic        smp_r, smp_nxt;

  // fifo storage, head entries prefetched into registers
  logic [7:0] tx_mem [FIFO_DEPTH];
  logic [7:0] rx_mem [FIFO_DEPTH];
  logic [7:0] tx_rd_r, rx_rd_r;

  logic          tx_we, rx_we;
  logic [AW-1:0] tx_waddr, rx_waddr;
  logic [7:0]    tx_wdata, rx_wdata;
  logic [AW:0]   tx_sum, rx_sum;

  logic [15:0] div_masked, half_per;
  logic [15:0] ticks_inc;
  logic [3:0]  bits_dec;
  logic [7:0]  shift_in;
  logic [31:0] rd_val;

  assign advance   = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall  = s1_valid_r && !advance;
  assign out_valid = out_valid_r;
  assign out_data  = out_item_r;

  assign div_masked = div_r & DIV_MASK;
  assign half_per   = (div_masked == 16'd0) ? HALF_PER_MAX : (div_masked >> 1);
  assign ticks_inc  = ticks_r + 16'd1;
  assign bits_dec   = bits_r - 4'd1;
  assign shift_in   = {shift_r[6:0], smp_r};

  // tail addresses, head + count wrapped once
  assign tx_sum   = {1'b0, tx_head_r} + (AW+1)'(tx_count_r);
  assign rx_sum   = {1'b0, rx_head_r} + (AW+1)'(rx_count_r);
  assign tx_waddr = (tx_sum >= DEPTH_EXT) ? AW'(tx_sum - DEPTH_EXT) : tx_sum[AW-1:0];
  assign rx_waddr = (rx_sum >= DEPTH_EXT) ? AW'(rx_sum - DEPTH_EXT) : rx_sum[AW-1:0];
  assign tx_wdata = s1_item_r.write_data[7:0];

  always_comb begin
    tx_head_nxt  = tx_head_r;
    tx_count_nxt = tx_count_r;
    rx_head_nxt  = rx_head_r;
    rx_count_nxt = rx_count_r;
    active_nxt   = active_r;
    shift_nxt    = shift_r;
    bits_nxt     = bits_r;
    ticks_nxt    = ticks_r;
    lvl_nxt      = lvl_r;
    smp_nxt      = smp_r;
    tx_we        = 1'b0;
    rx_we        = 1'b0;
    rx_wdata     = shift_in;
    rd_val       = 32'd0;
    if (advance) begin
      unique case (s1_item_r.cmd)
        CMD_TICK: begin
          if (!active_r) begin
            bits_nxt  = 4'd0;
            ticks_nxt = 16'd0;
            lvl_nxt   = 1'b0;
            smp_nxt   = 1'b0;
          end else if (bits_r == 4'd0) begin
            // load next byte when there is one and room for its answer
            if (tx_count_r != '0 && rx_count_r < CNT_FULL) begin
              shift_nxt    = tx_rd_r;
              tx_head_nxt  = (tx_head_r == HEAD_LAST) ? '0 : tx_head_r + 1'b1;
              tx_count_nxt = tx_count_r - 1'b1;
              bits_nxt     = 4'd8;
              ticks_nxt    = 16'd0;
              lvl_nxt      = 1'b0;
            end
          end else if (ticks_inc < half_per) begin
            ticks_nxt = ticks_inc;
          end else begin
            ticks_nxt = 16'd0;
            if (!lvl_r) begin
              lvl_nxt = 1'b1;
              smp_nxt = s1_item_r.miso;
            end else begin
              lvl_nxt   = 1'b0;
              shift_nxt = shift_in;
              bits_nxt  = bits_dec;
              if (bits_dec == 4'd0 && rx_count_r < CNT_FULL) begin
                rx_we        = 1'b1;
                rx_count_nxt = rx_count_r + 1'b1;
              end
            end
          end
        end
        CMD_WRITE: begin
          if (s1_item_r.reg_index == REG_CTRL) begin
            if (s1_item_r.write_data[CTRL_CLR_TX_BIT]) begin
              tx_head_nxt  = '0;
              tx_count_nxt = '0;
            end
            if (s1_item_r.write_data[CTRL_CLR_RX_BIT]) begin
              rx_head_nxt  = '0;
              rx_count_nxt = '0;
            end
            active_nxt = s1_item_r.write_data[CTRL_TA_BIT];
            if (!s1_item_r.write_data[CTRL_TA_BIT]) begin
              bits_nxt  = 4'd0;
              ticks_nxt = 16'd0;
              lvl_nxt   = 1'b0;
              smp_nxt   = 1'b0;
            end
          end else if (tx_count_r < CNT_FULL) begin
            tx_we        = 1'b1;
            tx_count_nxt = tx_count_r + 1'b1;
          end
        end
        CMD_READ: begin
          if (s1_item_r.reg_index == REG_CTRL) begin
            rd_val[STAT_TXD_BIT]  = (tx_count_r < CNT_FULL);
            rd_val[STAT_RXD_BIT]  = (rx_count_r != '0);
            rd_val[STAT_DONE_BIT] = active_r && tx_count_r == '0 && bits_r == 4'd0;
            rd_val[STAT_TA_BIT]   = active_r;
          end else if (rx_count_r != '0) begin
            rd_val       = {24'd0, rx_rd_r};
            rx_head_nxt  = (rx_head_r == HEAD_LAST) ? '0 : rx_head_r + 1'b1;
            rx_count_nxt = rx_count_r - 1'b1;
          end
        end
        default: begin
          // unused command, state holds
        end
      endcase
    end
  end

  // fifo writes and head prefetch, new data forwarded when it lands at the head
  always_ff @(posedge clk) begin
    if (tx_we) begin
      tx_mem[tx_waddr] <= tx_wdata;
    end
    if (tx_we && tx_waddr == tx_head_nxt) begin
      tx_rd_r <= tx_wdata;
    end else begin
      tx_rd_r <= tx_mem[tx_head_nxt];
    end
  end

  always_ff @(posedge clk) begin
    if (rx_we) begin
      rx_mem[rx_waddr] <= rx_wdata;
    end
    if (rx_we && rx_waddr == rx_head_nxt) begin
      rx_rd_r <= rx_wdata;
    end else begin
      rx_rd_r <= rx_mem[rx_head_nxt];
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_item_r <= in_data;
    end
    if (advance) begin
      out_item_r.read_data <= rd_val;
      out_item_r.sclk      <= lvl_nxt;
      out_item_r.mosi      <= (bits_nxt != 4'd0) ? shift_nxt[7] : 1'b0;
      out_item_r.select_n  <= !active_nxt;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      div_r       <= 16'd0;
      tx_head_r   <= '0;
      tx_count_r  <= '0;
      rx_head_r   <= '0;
      rx_count_r  <= '0;
      active_r    <= 1'b0;
      shift_r     <= 8'd0;
      bits_r      <= 4'd0;
      ticks_r     <= 16'd0;
      lvl_r       <= 1'b0;
      smp_r       <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        s1_valid_r <= 1'b1;
      end else if (advance) begin
        s1_valid_r <= 1'b0;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_we) begin
        div_r <= cfg_wdata;
      end
      tx_head_r  <= tx_head_nxt;
      tx_count_r <= tx_count_nxt;
      rx_head_r  <= rx_head_nxt;
      rx_count_r <= rx_count_nxt;
      active_r   <= active_nxt;
      shift_r    <= shift_nxt;
      bits_r     <= bits_nxt;
      ticks_r    <= ticks_nxt;
      lvl_r      <= lvl_nxt;
      smp_r      <= smp_nxt;
    end
  end

endmodule

`default_nettype wire
